// ===== design/pulsing_led_level_controller_unit_macros.svh =====
// Assertion macros used by the level controller's control module.
`ifndef PULSING_LED_LEVEL_CONTROLLER_UNIT_MACROS_SVH
`define PULSING_LED_LEVEL_CONTROLLER_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PLLD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("plld assertion failed");

// Check that a condition in one cycle leads to another in the next.
`define PLLD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("plld assertion failed");

`endif

// ===== design/plld_pkg.sv =====
// Types and constants shared by the level controller modules.
package plld_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned ColorW    = 8;
  localparam int unsigned PeriodW   = 13;
  localparam int unsigned LimitW    = 17;
  localparam int unsigned LevelW    = 18;
  localparam int          LevelMax  = 131071;
  localparam int          LevelMin  = -131072;
  localparam int unsigned IdleMs    = 500;
  localparam int unsigned NumColors = 3;
  localparam int unsigned ColIdxW   = 2;

  // Shared divider sizes: 32-bit dividend, divisor up to twice the period.
  localparam int unsigned DivW      = 32;
  localparam int unsigned DivisorW  = PeriodW + 1;

  // APB port
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;

  localparam logic [PeriodW-1:0] PeriodReset = 13'd2000;
  localparam logic [LimitW-1:0]  LowerReset  = 17'd3277;
  localparam logic [LimitW-1:0]  UpperReset  = 17'd39322;
  localparam logic [LimitW-1:0]  GainReset   = 17'd65536;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_COLOR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_LOWER  = 2'd1,
    REG_UPPER  = 2'd2,
    REG_GAIN   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic [LimitW-1:0]  lower;
    logic [LimitW-1:0]  upper;
    logic [LimitW-1:0]  gain;
  } cfg_t;

  typedef struct packed {
    logic               load;
    logic               div_start;
    logic               div_map;
    logic               t_cap;
    logic               wave_cap;
    logic               upd;
    logic               lg_cap;
    logic               col_cap;
    logic [ColIdxW-1:0] col_idx;
    logic               out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic period_zero;
    logic div_done;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== design/plld_in_if.sv =====
// Input channel: command beat with time stamps and color.
interface plld_in_if;
  import plld_pkg::*;

  logic                valid;
  logic                ready;
  logic [CmdW-1:0]     command;
  logic [TimeW-1:0]    now_ms;
  logic [TimeW-1:0]    last_point_ms;
  logic [ColorW-1:0]   red_in;
  logic [ColorW-1:0]   green_in;
  logic [ColorW-1:0]   blue_in;

  modport source (
    output valid, command, now_ms, last_point_ms, red_in, green_in, blue_in,
    input  ready
  );

  modport sink (
    input  valid, command, now_ms, last_point_ms, red_in, green_in, blue_in,
    output ready
  );
endinterface

// ===== design/plld_out_if.sv =====
// Output channel: level, mode and scaled color beat.
interface plld_out_if;
  import plld_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [LevelW-1:0] level_out;
  logic                     pulsing_out;
  logic [ColorW-1:0]        red_out;
  logic [ColorW-1:0]        green_out;
  logic [ColorW-1:0]        blue_out;

  modport source (
    output valid, level_out, pulsing_out, red_out, green_out, blue_out,
    input  ready
  );

  modport sink (
    input  valid, level_out, pulsing_out, red_out, green_out, blue_out,
    output ready
  );
endinterface

// ===== design/plld_regs.sv =====
// APB configuration register file.
module plld_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [plld_pkg::AddrW-1:0] paddr,
  input  logic [plld_pkg::DataW-1:0] pwdata,
  output logic [plld_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output plld_pkg::cfg_t             cfg_o
);
  import plld_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PERIOD: cfg_d.period = pwdata[PeriodW-1:0];
        REG_LOWER:  cfg_d.lower  = pwdata[LimitW-1:0];
        REG_UPPER:  cfg_d.upper  = pwdata[LimitW-1:0];
        REG_GAIN:   cfg_d.gain   = pwdata[LimitW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PERIOD: prdata = DataW'(cfg_q.period);
      REG_LOWER:  prdata = DataW'(cfg_q.lower);
      REG_UPPER:  prdata = DataW'(cfg_q.upper);
      REG_GAIN:   prdata = DataW'(cfg_q.gain);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period <= PeriodReset;
      cfg_q.lower  <= LowerReset;
      cfg_q.upper  <= UpperReset;
      cfg_q.gain   <= GainReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end
endmodule

// ===== design/plld_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module plld_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [plld_pkg::DivW-1:0]     dividend_i,
  input  logic [plld_pkg::DivisorW-1:0] divisor_i,
  output logic                          done_o,
  output logic [plld_pkg::DivW-1:0]     quo_o,
  output logic [plld_pkg::DivisorW-1:0] rem_o
);
  import plld_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DivW-1:0]     quo_q, quo_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] dsr_q, dsr_d;
  logic [DivisorW:0]   rem_sh;
  logic [DivisorW:0]   rem_sub;
  logic                ge;

  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // shift in the next dividend bit and subtract where it fits
      rem_d = ge ? rem_sub[DivisorW-1:0] : rem_sh[DivisorW-1:0];
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

// ===== design/plld_dp.sv =====
// Datapath: wave, level update, color scaling and output register.
module plld_dp #(
  parameter int unsigned TIME_BITS       = 32,
  parameter int unsigned LEVEL_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  plld_pkg::cfg_t                     cfg_i,
  input  plld_pkg::ctrl_cmd_t                ctrl_i,
  output plld_pkg::dp_sts_t                  sts_o,
  input  logic [plld_pkg::CmdW-1:0]          command_i,
  input  logic [plld_pkg::TimeW-1:0]         now_ms_i,
  input  logic [plld_pkg::TimeW-1:0]         last_point_ms_i,
  input  logic [plld_pkg::ColorW-1:0]        red_i,
  input  logic [plld_pkg::ColorW-1:0]        green_i,
  input  logic [plld_pkg::ColorW-1:0]        blue_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [plld_pkg::LevelW-1:0] level_o,
  output logic                               pulsing_o,
  output logic [plld_pkg::ColorW-1:0]        red_o,
  output logic [plld_pkg::ColorW-1:0]        green_o,
  output logic [plld_pkg::ColorW-1:0]        blue_o
);
  import plld_pkg::*;

  localparam int unsigned WideW     = LevelW + 2;
  localparam int unsigned TW        = PeriodW;
  localparam int unsigned ProdW     = LimitW + PeriodW;
  localparam int unsigned LgW       = 2 * LimitW;
  localparam int unsigned ColProdW  = ColorW + LgW;
  localparam int unsigned ColShift  = 2 * LEVEL_FRAC_BITS;
  localparam int unsigned DecayStep = ((1 << LEVEL_FRAC_BITS) + 50) / 100;
  localparam logic signed [WideW-1:0]  WideMax  = WideW'(LevelMax);
  localparam logic signed [WideW-1:0]  WideMin  = WideW'(LevelMin);
  localparam logic signed [LevelW-1:0] LevelOne = (LEVEL_FRAC_BITS >= LevelW - 1) ?
                                                  LevelW'(LevelMax) :
                                                  LevelW'(1 << LEVEL_FRAC_BITS);

  function automatic logic signed [LevelW-1:0] sat_lvl(input logic signed [WideW-1:0] v);
    logic signed [LevelW-1:0] r;
    if (v > WideMax) begin
      r = LevelW'(LevelMax);
    end else if (v < WideMin) begin
      r = LevelW'(LevelMin);
    end else begin
      r = v[LevelW-1:0];
    end
    return r;
  endfunction

  // input beat
  cmd_e                cmd_q;
  logic [TimeW-1:0]    now_q;
  logic [TimeW-1:0]    last_q;
  logic [ColorW-1:0]   rin_q, gin_q, bin_q;

  // working state
  logic signed [LevelW-1:0] level_q, level_d;
  logic                     pulsing_q, pulsing_d;
  logic signed [LevelW-1:0] wave_q;
  logic [ProdW-1:0]         prod_mag_q;
  logic                     prod_neg_q;
  logic [LgW-1:0]           lg_q;
  logic [ColorW-1:0]        colr_q, colg_q, colb_q;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic signed [LevelW-1:0] out_level_q;
  logic                     out_pulsing_q;
  logic [ColorW-1:0]        out_r_q, out_g_q, out_b_q;

  // divider
  logic [DivW-1:0]     div_dividend;
  logic [DivisorW-1:0] div_divisor;
  logic                div_done;
  logic [DivW-1:0]     div_quo;
  logic [DivisorW-1:0] div_rem;

  assign div_dividend = ctrl_i.div_map ? DivW'(prod_mag_q) : now_q;
  assign div_divisor  = ctrl_i.div_map ? {1'b0, cfg_i.period} : {cfg_i.period, 1'b0};

  plld_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // triangle phase and slope product
  logic [DivisorW-1:0]      per_ext;
  logic [DivisorW-1:0]      t_full;
  logic [TW-1:0]            t_val;
  logic signed [LevelW-1:0] diff;
  logic [LevelW-1:0]        diff_abs;
  logic [ProdW-1:0]         prod;

  assign per_ext  = {1'b0, cfg_i.period};
  assign t_full   = (div_rem >= per_ext) ? (div_rem - per_ext) : (per_ext - div_rem);
  assign t_val    = t_full[TW-1:0];
  assign diff     = $signed({1'b0, cfg_i.upper}) - $signed({1'b0, cfg_i.lower});
  assign diff_abs = diff[LevelW-1] ? LevelW'(-diff) : LevelW'(diff);
  assign prod     = diff_abs[LimitW-1:0] * t_val;

  // wave from quotient, truncated toward zero
  logic signed [WideW-1:0] lo_w;
  logic signed [WideW-1:0] q_w;
  logic signed [WideW-1:0] wave_sum;

  assign lo_w     = $signed(WideW'(cfg_i.lower));
  assign q_w      = $signed(WideW'(div_quo[LimitW-1:0]));
  assign wave_sum = prod_neg_q ? (lo_w - q_w) : (lo_w + q_w);

  // level update
  logic [TIME_BITS-1:0]     elapsed;
  logic signed [WideW-1:0]  lvl_w;
  logic signed [WideW-1:0]  dec_w;
  logic signed [LevelW-1:0] dec_lvl;

  assign elapsed = TIME_BITS'(now_q) - TIME_BITS'(last_q);
  assign lvl_w   = {{(WideW - LevelW){level_q[LevelW-1]}}, level_q};
  assign dec_w   = lvl_w - $signed(WideW'(DecayStep));
  assign dec_lvl = sat_lvl(dec_w);

  always_comb begin
    level_d   = level_q;
    pulsing_d = pulsing_q;
    unique case (cmd_q)
      CMD_TICK: begin
        if (!pulsing_q && (elapsed > TIME_BITS'(IdleMs))) begin
          level_d = dec_lvl;
          if (dec_lvl < wave_q) pulsing_d = 1'b1;
        end
        if (pulsing_d) level_d = wave_q;
      end
      CMD_START: pulsing_d = 1'b1;
      CMD_STOP: begin
        pulsing_d = 1'b0;
        level_d   = LevelOne;
      end
      CMD_COLOR: level_d = level_q;
      default:   level_d = level_q;
    endcase
  end

  // color scaling, one channel per cycle
  logic [ColorW-1:0]   col_in;
  logic [ColProdW-1:0] col_prod;
  logic [ColProdW-1:0] col_shift;
  logic [ColorW-1:0]   col_val;
  logic                level_pos;

  always_comb begin
    unique case (ctrl_i.col_idx)
      ColIdxW'(0): col_in = rin_q;
      ColIdxW'(1): col_in = gin_q;
      ColIdxW'(2): col_in = bin_q;
      default:     col_in = '0;
    endcase
  end

  assign level_pos = !level_q[LevelW-1] && (level_q != '0);
  assign col_prod  = col_in * lg_q;
  assign col_shift = col_prod >> ColShift;
  assign col_val   = !level_pos ? '0 :
                     (col_shift > ColProdW'({ColorW{1'b1}})) ? {ColorW{1'b1}} :
                     col_shift[ColorW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_e'(command_i);
      now_q  <= now_ms_i;
      last_q <= last_point_ms_i;
      rin_q  <= red_i;
      gin_q  <= green_i;
      bin_q  <= blue_i;
      // a zero period leaves the wave at the lower limit
      wave_q <= $signed({1'b0, cfg_i.lower});
      colr_q <= '0;
      colg_q <= '0;
      colb_q <= '0;
    end
    if (ctrl_i.t_cap) begin
      prod_mag_q <= prod;
      prod_neg_q <= diff[LevelW-1];
    end
    if (ctrl_i.wave_cap) wave_q <= sat_lvl(wave_sum);
    if (ctrl_i.lg_cap) lg_q <= level_q[LimitW-1:0] * cfg_i.gain;
    if (ctrl_i.col_cap) begin
      unique case (ctrl_i.col_idx)
        ColIdxW'(0): colr_q <= col_val;
        ColIdxW'(1): colg_q <= col_val;
        default:     colb_q <= col_val;
      endcase
    end
    if (ctrl_i.out_load) begin
      out_level_q   <= level_q;
      out_pulsing_q <= pulsing_q;
      out_r_q       <= colr_q;
      out_g_q       <= colg_q;
      out_b_q       <= colb_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      pulsing_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.upd) begin
        level_q   <= level_d;
        pulsing_q <= pulsing_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.cmd         = cmd_q;
  assign sts_o.period_zero = (cfg_i.period == '0);
  assign sts_o.div_done    = div_done;
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;
  assign pulsing_o   = out_pulsing_q;
  assign red_o       = out_r_q;
  assign green_o     = out_g_q;
  assign blue_o      = out_b_q;
endmodule

// ===== design/plld_ctrl.sv =====
// Controller: sequences one beat through the datapath.
module plld_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plld_pkg::dp_sts_t   sts_i,
  output plld_pkg::ctrl_cmd_t ctrl_o
);
  import plld_pkg::*;

  `include "pulsing_led_level_controller_unit_macros.svh"

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_DISP = 12'b0000_0000_0010,
    S_MOD  = 12'b0000_0000_0100,
    S_MODW = 12'b0000_0000_1000,
    S_TCAP = 12'b0000_0001_0000,
    S_MAP  = 12'b0000_0010_0000,
    S_MAPW = 12'b0000_0100_0000,
    S_WAVE = 12'b0000_1000_0000,
    S_UPD  = 12'b0001_0000_0000,
    S_LG   = 12'b0010_0000_0000,
    S_COL  = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [ColIdxW-1:0] chan_q, chan_d;

  always_comb begin
    state_d    = state_q;
    chan_d     = chan_q;
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    ctrl_o.col_idx = chan_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.cmd)
          CMD_TICK:  state_d = sts_i.period_zero ? S_UPD : S_MOD;
          CMD_START: state_d = S_UPD;
          CMD_STOP:  state_d = S_UPD;
          CMD_COLOR: state_d = S_LG;
          default:   state_d = S_UPD;
        endcase
      end
      S_MOD: begin
        ctrl_o.div_start = 1'b1;
        state_d          = S_MODW;
      end
      S_MODW: begin
        if (sts_i.div_done) state_d = S_TCAP;
      end
      S_TCAP: begin
        ctrl_o.t_cap = 1'b1;
        state_d      = S_MAP;
      end
      S_MAP: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_map   = 1'b1;
        state_d          = S_MAPW;
      end
      S_MAPW: begin
        if (sts_i.div_done) state_d = S_WAVE;
      end
      S_WAVE: begin
        ctrl_o.wave_cap = 1'b1;
        state_d         = S_UPD;
      end
      S_UPD: begin
        ctrl_o.upd = 1'b1;
        state_d    = S_OUT;
      end
      S_LG: begin
        ctrl_o.lg_cap = 1'b1;
        chan_d        = '0;
        state_d       = S_COL;
      end
      S_COL: begin
        ctrl_o.col_cap = 1'b1;
        if (chan_q == ColIdxW'(NumColors - 1)) begin
          chan_d  = '0;
          state_d = S_OUT;
        end else begin
          chan_d = chan_q + 1'b1;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!sts_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chan_q  <= '0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
    end
  end

  `PLLD_ASSERT_NEXT(a_one_beat_at_a_time, in_valid_i && in_ready_o, !in_ready_o)
  `PLLD_ASSERT(a_div_done_when_waiting, !sts_i.div_done || state_q == S_MODW || state_q == S_MAPW)
  `PLLD_ASSERT(a_color_only_for_color_cmd, !ctrl_o.col_cap || sts_i.cmd == CMD_COLOR)
endmodule

// ===== design/pulsing_led_level_controller_unit.sv =====
// Tick: the result is set by two 32-step passes of the shared divider, skipped for a zero period.
// Start and stop go straight to the level update. Color: one channel multiply per cycle.
// One beat in flight; the next beat is taken in the cycle after the result is loaded,
// while that result may still wait in the output register.
// Reset (async, active low): level 0, pulsing on, registers at their defaults.
module pulsing_led_level_controller_unit #(
  parameter int unsigned TIME_BITS       = 32,
  parameter int unsigned LEVEL_FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  plld_in_if.sink                    in_i,
  plld_out_if.source                 out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [plld_pkg::AddrW-1:0] paddr,
  input  logic [plld_pkg::DataW-1:0] pwdata,
  output logic [plld_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import plld_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t ctrl;
  dp_sts_t   sts;
  logic      in_ready;

  plld_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  plld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .ctrl_o     (ctrl)
  );

  plld_dp #(
    .TIME_BITS       (TIME_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .ctrl_i          (ctrl),
    .sts_o           (sts),
    .command_i       (in_i.command),
    .now_ms_i        (in_i.now_ms),
    .last_point_ms_i (in_i.last_point_ms),
    .red_i           (in_i.red_in),
    .green_i         (in_i.green_in),
    .blue_i          (in_i.blue_in),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .level_o         (out_o.level_out),
    .pulsing_o       (out_o.pulsing_out),
    .red_o           (out_o.red_out),
    .green_o         (out_o.green_out),
    .blue_o          (out_o.blue_out)
  );

  assign in_i.ready = in_ready;
endmodule

// ===== sim/tb_pulsing_led_level_controller_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the breathing-LED level controller: predicts every beat and compares.
module tb_pulsing_led_level_controller_unit;
  import plld_pkg::*;

  localparam longint OneLevel   = longint'(1) << 16;
  localparam longint DecayStep  = (OneLevel + 50) / 100;
  localparam int     IdlePct    = 16;
  localparam int     StallLen   = 400;
  localparam int     StallAt    = 120;
  localparam int     SteadyFrom = 250;
  localparam int     SteadyTo   = 330;
  localparam int     WatchLimit = 2000;
  localparam int     DrainWait  = 100;

  typedef struct packed {
    cmd_e              command;
    logic [TimeW-1:0]  now_ms;
    logic [TimeW-1:0]  last_ms;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } led_beat_t;

  typedef struct packed {
    logic signed [LevelW-1:0] level;
    logic                     pulsing;
    logic [ColorW-1:0]        red;
    logic [ColorW-1:0]        green;
    logic [ColorW-1:0]        blue;
  } led_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  plld_in_if  in_if ();
  plld_out_if out_if ();

  pulsing_led_level_controller_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state and register copies
  logic [PeriodW-1:0] cfg_period;
  logic [LimitW-1:0]  cfg_lower;
  logic [LimitW-1:0]  cfg_upper;
  logic [LimitW-1:0]  cfg_gain;
  longint             led_level;
  logic               led_pulsing;

  led_beat_t   beat_q[$];
  led_result_t level_results_q[$];
  led_beat_t   offered_beat;

  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned fail_count;
  int unsigned decay_ticks;
  int unsigned pulse_resumes;
  int unsigned settings_used;
  int unsigned stall_left;
  bit          stall_done;
  int unsigned quiet_cycles;

  function automatic longint clip_level(longint v);
    if (v > LevelMax) return LevelMax;
    if (v < LevelMin) return LevelMin;
    return v;
  endfunction

  // Triangle over 2P, mapped from lower (t = 0) to upper (t = P).
  function automatic longint wave_at(logic [TimeW-1:0] now);
    longint p;
    longint t;
    p = longint'(cfg_period);
    if (p == 0) return clip_level(longint'(cfg_lower));
    t = (longint'(now) % (2 * p)) - p;
    if (t < 0) t = -t;
    return clip_level(longint'(cfg_lower) +
                      ((longint'(cfg_upper) - longint'(cfg_lower)) * t) / p);
  endfunction

  function automatic logic [ColorW-1:0] dim_channel(logic [ColorW-1:0] c);
    longint prod;
    if (led_level <= 0) return '0;
    prod = (longint'(c) * led_level * longint'(cfg_gain)) >>> 32;
    return (prod > 255) ? 8'd255 : prod[ColorW-1:0];
  endfunction

  function automatic led_result_t predict_beat(led_beat_t b);
    led_result_t res;
    longint      w;
    logic [TimeW-1:0] elapsed;
    res = '0;
    case (b.command)
      CMD_TICK: begin
        w = wave_at(b.now_ms);
        elapsed = b.now_ms - b.last_ms;
        if (!led_pulsing && elapsed > IdleMs) begin
          led_level = clip_level(led_level - DecayStep);
          decay_ticks++;
          if (led_level < w) begin
            led_pulsing = 1'b1;
            pulse_resumes++;
          end
        end
        if (led_pulsing) led_level = w;
      end
      CMD_START: led_pulsing = 1'b1;
      CMD_STOP: begin
        led_pulsing = 1'b0;
        led_level = clip_level(OneLevel);
      end
      default: begin
        res.red   = dim_channel(b.red);
        res.green = dim_channel(b.green);
        res.blue  = dim_channel(b.blue);
      end
    endcase
    res.level   = led_level[LevelW-1:0];
    res.pulsing = led_pulsing;
    return res;
  endfunction

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Driver: hold a beat until taken, then present the next one or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        level_results_q.push_back(predict_beat(offered_beat));
        beats_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (beat_q.size() != 0 &&
            ((beats_sent >= SteadyFrom && beats_sent < SteadyTo) ||
             $urandom_range(99) >= IdlePct)) begin
          offered_beat = beat_q.pop_front();
          in_if.command       <= offered_beat.command;
          in_if.now_ms        <= offered_beat.now_ms;
          in_if.last_point_ms <= offered_beat.last_ms;
          in_if.red_in        <= offered_beat.red;
          in_if.green_in      <= offered_beat.green;
          in_if.blue_in       <= offered_beat.blue;
          in_if.valid         <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat, then drive ready with random stalls and one long stall.
  always @(posedge clk_i) begin
    led_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (level_results_q.size() == 0) begin
          $error("result beat arrived with nothing expected");
          fail_count++;
        end else begin
          want = level_results_q.pop_front();
          check_field("level_out", 32'(want.level), 32'(out_if.level_out));
          check_field("pulsing_out", {31'b0, want.pulsing}, {31'b0, out_if.pulsing_out});
          check_field("red_out", {24'b0, want.red}, {24'b0, out_if.red_out});
          check_field("green_out", {24'b0, want.green}, {24'b0, out_if.green_out});
          check_field("blue_out", {24'b0, want.blue}, {24'b0, out_if.blue_out});
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!stall_done && results_seen >= StallAt) begin
        stall_done = 1'b1;
        stall_left = StallLen;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= (results_seen >= SteadyFrom && results_seen < SteadyTo) ||
                        ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no beat on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchLimit) begin
          $error("no beat accepted for %0d cycles", quiet_cycles);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  task automatic add_beat(cmd_e cmd, logic [TimeW-1:0] now, logic [TimeW-1:0] last,
                          logic [ColorW-1:0] r, logic [ColorW-1:0] g, logic [ColorW-1:0] b);
    led_beat_t nb;
    nb.command = cmd;
    nb.now_ms  = now;
    nb.last_ms = last;
    nb.red     = r;
    nb.green   = g;
    nb.blue    = b;
    beat_q.push_back(nb);
  endtask

  // Mostly stop-then-decay runs, plus loose ticks, colors and random commands.
  task automatic add_random_beats(int unsigned count);
    int unsigned added;
    int unsigned run_len;
    int unsigned pick;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] last;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        run_len = ($urandom_range(9) == 0) ? $urandom_range(60, 110) : $urandom_range(2, 40);
        now = $urandom;
        add_beat(CMD_STOP, $urandom, $urandom, ColorW'($urandom), ColorW'($urandom),
                 ColorW'($urandom));
        added++;
        repeat (run_len) begin
          now += $urandom_range(1, 3000);
          last = ($urandom_range(7) == 0) ? now - $urandom_range(0, 500)
                                          : now - $urandom_range(501, 100000);
          if ($urandom_range(9) == 0)
            add_beat(CMD_COLOR, now, last, ColorW'($urandom), ColorW'($urandom),
                     ColorW'($urandom));
          else
            add_beat(CMD_TICK, now, last, ColorW'($urandom), ColorW'($urandom),
                     ColorW'($urandom));
          added++;
        end
      end else begin
        if (pick < 70)
          add_beat(CMD_TICK, $urandom, $urandom, ColorW'($urandom), ColorW'($urandom),
                   ColorW'($urandom));
        else if (pick < 88)
          add_beat(CMD_COLOR, $urandom, $urandom, ColorW'($urandom), ColorW'($urandom),
                   ColorW'($urandom));
        else
          add_beat(cmd_e'($urandom_range(3)), $urandom, $urandom, ColorW'($urandom),
                   ColorW'($urandom), ColorW'($urandom));
        added++;
      end
    end
  endtask

  // Sample at the falling edge so queue and valid updates have settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (beat_q.size() != 0 || in_if.valid || level_results_q.size() != 0);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PERIOD: cfg_period = value[PeriodW-1:0];
      REG_LOWER:  cfg_lower  = value[LimitW-1:0];
      REG_UPPER:  cfg_upper  = value[LimitW-1:0];
      default:    cfg_gain   = value[LimitW-1:0];
    endcase
  endtask

  task automatic apply_settings(logic [PeriodW-1:0] period, logic [LimitW-1:0] lower,
                                logic [LimitW-1:0] upper, logic [LimitW-1:0] gain);
    wait_drained();
    write_reg(REG_PERIOD, DataW'(period));
    write_reg(REG_LOWER, DataW'(lower));
    write_reg(REG_UPPER, DataW'(upper));
    write_reg(REG_GAIN, DataW'(gain));
    settings_used++;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = CMD_TICK;
    in_if.now_ms = '0;
    in_if.last_point_ms = '0;
    in_if.red_in = '0;
    in_if.green_in = '0;
    in_if.blue_in = '0;
    out_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_period = PeriodReset;
    cfg_lower = LowerReset;
    cfg_upper = UpperReset;
    cfg_gain = GainReset;
    led_level = 0;
    led_pulsing = 1'b1;
    settings_used = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset values, field extremes, idle threshold and time wrap.
    add_beat(CMD_COLOR, 32'h0, 32'h0, 8'hFF, 8'hFF, 8'hFF);
    add_beat(CMD_TICK, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00);
    add_beat(CMD_COLOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'h80, 8'h01);
    add_beat(CMD_TICK, 32'd2000, 32'd0, 8'hFF, 8'hFF, 8'hFF);
    add_beat(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 8'hFF, 8'h00);
    add_beat(CMD_STOP, 32'hFFFF_FFFF, 32'h0, 8'hFF, 8'h00, 8'hFF);
    add_beat(CMD_COLOR, 32'h0, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
    add_beat(CMD_TICK, 32'd1000, 32'd500, 8'h00, 8'h00, 8'h00);
    add_beat(CMD_TICK, 32'd1501, 32'd1000, 8'h00, 8'h00, 8'h00);
    add_beat(CMD_TICK, 32'd100, 32'hFFFF_FF00, 8'h00, 8'h00, 8'h00);
    add_beat(CMD_TICK, 32'h0, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00);
    add_beat(CMD_TICK, 32'h10, 32'h20, 8'h00, 8'h00, 8'h00);
    add_beat(CMD_COLOR, 32'h0, 32'h0, 8'h7F, 8'h01, 8'hFE);
    add_beat(CMD_START, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00);
    add_beat(CMD_TICK, 32'hFFFF_FFFF, 32'h0, 8'h00, 8'h00, 8'h00);
    add_beat(CMD_COLOR, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00);
    add_beat(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
    add_beat(CMD_STOP, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00);
    add_beat(CMD_STOP, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00);
    add_random_beats(80);

    // Zero period with inverted limits and no brightness.
    apply_settings(13'd0, 17'd65536, 17'd0, 17'd0);
    add_beat(CMD_TICK, 32'h1234_5678, 32'h0, 8'h00, 8'h00, 8'h00);
    add_beat(CMD_COLOR, 32'h0, 32'h0, 8'hFF, 8'hFF, 8'hFF);
    add_random_beats(70);

    apply_settings(13'd500, 17'd0, 17'd65536, 17'd65536);
    add_random_beats(80);

    apply_settings(13'h1FFF, 17'd65536, 17'd3277, 17'd32768);
    add_random_beats(80);

    // Level beyond 1.0 and gain beyond 1.0: colors clamp at full scale.
    apply_settings(13'd1, 17'd0, 17'h1FFFF, 17'h1FFFF);
    add_beat(CMD_TICK, 32'd0, 32'd0, 8'h00, 8'h00, 8'h00);
    add_beat(CMD_COLOR, 32'd0, 32'd0, 8'hFF, 8'h01, 8'h80);
    add_random_beats(80);

    // Flat zero wave: decay runs all the way down before pulsing resumes.
    apply_settings(13'd5000, 17'd0, 17'd0, 17'd65536);
    add_random_beats(80);

    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    $display("Checked %0d beats over %0d register settings.", beats_sent, settings_used);
    $display("Decay ticks: %0d, pulsing resumed from decay: %0d times.",
             decay_ticks, pulse_resumes);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
